// ----- hdl/tps_pkg.sv -----
// tps_pkg: shared types and constants of the min-first topological sorter.
// Holds field widths, function codes, controller states and the command and
// status records between controller and datapath. Depends on nothing.
`default_nettype none

package tps_pkg;

	localparam int VTX_W            = 6;
	localparam int VCNT_W           = 7;
	localparam int EDGE_W           = 2 * VTX_W;
	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_MAX_EDGES    = 1024;

	localparam logic [VCNT_W-1:0] VCOUNT_RESET = 7'd64;

	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_FINISH = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLR,
		ST_CNT_EDGE,
		ST_CNT_CHECK,
		ST_CNT_WRITE,
		ST_INIT,
		ST_PICK,
		ST_SCAN_EDGE,
		ST_SCAN_CHECK,
		ST_SCAN_WRITE,
		ST_EMIT,
		ST_FAIL
	} tps_state_t;

	typedef struct packed {
		logic add_edge;
		logic clr_wr;
		logic edge_rd;
		logic deg_rd;
		logic deg_inc;
		logic deg_dec;
		logic ready_init;
		logic take_pick;
		logic idx_clear;
		logic idx_next;
		logic emit_vertex;
		logic emit_fail;
		logic run_clear;
	} tps_cmd_t;

	typedef struct packed {
		logic total_zero;
		logic idx_last;
		logic clr_last;
		logic cnt_hit;
		logic scan_hit;
		logic ready_empty;
		logic emit_last;
		logic out_free;
	} tps_status_t;

endpackage

`default_nettype wire

// ----- hdl/tps_if.sv -----
// tps_in_if / tps_out_if: valid-ready channels for command items and
// order result items. Depends on tps_pkg for the field widths.
`default_nettype none

interface tps_in_if import tps_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             func;
	logic [VTX_W-1:0] source_vertex;
	logic [VTX_W-1:0] target_vertex;

	modport source (output valid, output func, output source_vertex, output target_vertex,
		input ready);
	modport sink (input valid, input func, input source_vertex, input target_vertex,
		output ready);
endinterface

interface tps_out_if import tps_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VTX_W-1:0] vertex_index;
	logic             vertex_valid;
	logic             last_of_run;
	logic             order_complete;
	logic             edges_dropped;

	modport source (output valid, output vertex_index, output vertex_valid,
		output last_of_run, output order_complete, output edges_dropped, input ready);
	modport sink (input valid, input vertex_index, input vertex_valid,
		input last_of_run, input order_complete, input edges_dropped, output ready);
endinterface

`default_nettype wire

// ----- hdl/tps_ram.sv -----
// tps_ram: generic single-write, single-read RAM with registered read data.
// Used for the edge store and the in-degree table. No dependencies.
`default_nettype none

module tps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                                   clk,
	input  wire                                   we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                       wdata,
	input  wire                                   re,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tps_datapath.sv -----
// tps_datapath: edge store, in-degree table, ready mask, pick logic and the
// result register. Driven by tps_controller; uses tps_pkg and tps_ram.
`default_nettype none

module tps_datapath import tps_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire  [VCNT_W-1:0] cfg_wdata,
	input  wire  [VTX_W-1:0]  source_vertex,
	input  wire  [VTX_W-1:0]  target_vertex,
	input  tps_cmd_t          cmd,
	output tps_status_t       status,
	output logic              out_valid,
	input  wire               out_ready,
	output logic [VTX_W-1:0]  vertex_index,
	output logic              vertex_valid,
	output logic              last_of_run,
	output logic              order_complete,
	output logic              edges_dropped
);

	localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ET_W  = $clog2(MAX_EDGES + 1);
	localparam int DEG_W = $clog2(MAX_EDGES + 1);

	logic [VCNT_W-1:0]       vcount_q;
	logic [VCNT_W-1:0]       n_eff;
	logic [MAX_VERTICES-1:0] nmask;
	logic [ET_W-1:0]         edge_total_q;
	logic                    overflow_q;
	logic                    store_full;
	logic [EA_W-1:0]         idx_q;
	logic [IDX_W-1:0]        clr_q;
	logic [MAX_VERTICES-1:0] nz_q;
	logic [MAX_VERTICES-1:0] ready_q;
	logic [IDX_W-1:0]        pick_q;
	logic [IDX_W-1:0]        pick_next;
	logic [VCNT_W-1:0]       emit_cnt_q;
	logic                    out_valid_q;

	logic [EDGE_W-1:0]       edge_rdata;
	logic [VTX_W-1:0]        e_src;
	logic [VTX_W-1:0]        e_tgt;
	logic [IDX_W-1:0]        tgt_idx;
	logic [DEG_W-1:0]        deg_rdata;
	logic                    deg_we;
	logic [IDX_W-1:0]        deg_waddr;
	logic [DEG_W-1:0]        deg_wdata;

	// effective vertex count, saturated into 1..MAX_VERTICES
	always_comb begin
		if (vcount_q == '0) begin
			n_eff = VCNT_W'(1);
		end else if (vcount_q > VCNT_W'(MAX_VERTICES)) begin
			n_eff = VCNT_W'(MAX_VERTICES);
		end else begin
			n_eff = vcount_q;
		end
	end

	always_comb begin
		for (int v = 0; v < MAX_VERTICES; v++) begin
			nmask[v] = (VCNT_W'(v) < n_eff);
		end
	end

	// lowest set bit of the ready mask
	always_comb begin
		pick_next = '0;
		for (int v = MAX_VERTICES - 1; v >= 0; v--) begin
			if (ready_q[v]) begin
				pick_next = IDX_W'(v);
			end
		end
	end

	assign store_full = (edge_total_q >= ET_W'(MAX_EDGES));
	assign e_src      = edge_rdata[EDGE_W-1:VTX_W];
	assign e_tgt      = edge_rdata[VTX_W-1:0];
	assign tgt_idx    = e_tgt[IDX_W-1:0];

	tps_ram #(
		.WIDTH (EDGE_W),
		.DEPTH (MAX_EDGES)
	) u_edge_ram (
		.clk   (clk),
		.we    (cmd.add_edge && !store_full),
		.waddr (edge_total_q[EA_W-1:0]),
		.wdata ({source_vertex, target_vertex}),
		.re    (cmd.edge_rd),
		.raddr (idx_q),
		.rdata (edge_rdata)
	);

	always_comb begin
		deg_we    = 1'b0;
		deg_waddr = tgt_idx;
		deg_wdata = '0;
		if (cmd.clr_wr) begin
			deg_we    = 1'b1;
			deg_waddr = clr_q;
		end else if (cmd.deg_inc) begin
			deg_we    = 1'b1;
			deg_wdata = deg_rdata + DEG_W'(1);
		end else if (cmd.deg_dec && deg_rdata != '0) begin
			deg_we    = 1'b1;
			deg_wdata = deg_rdata - DEG_W'(1);
		end
	end

	tps_ram #(
		.WIDTH (DEG_W),
		.DEPTH (MAX_VERTICES)
	) u_deg_ram (
		.clk   (clk),
		.we    (deg_we),
		.waddr (deg_waddr),
		.wdata (deg_wdata),
		.re    (cmd.deg_rd),
		.raddr (tgt_idx),
		.rdata (deg_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q     <= VCOUNT_RESET;
			edge_total_q <= '0;
			overflow_q   <= 1'b0;
			idx_q        <= '0;
			clr_q        <= '0;
			nz_q         <= '0;
			ready_q      <= '0;
			pick_q       <= '0;
			emit_cnt_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			if (cmd.add_edge) begin
				if (store_full) begin
					overflow_q <= 1'b1;
				end else begin
					edge_total_q <= edge_total_q + ET_W'(1);
				end
			end
			if (cmd.clr_wr) begin
				clr_q <= (clr_q == IDX_W'(MAX_VERTICES - 1)) ? '0 : clr_q + IDX_W'(1);
			end
			if (cmd.idx_clear) begin
				idx_q <= '0;
			end else if (cmd.idx_next) begin
				idx_q <= idx_q + EA_W'(1);
			end
			if (cmd.deg_inc) begin
				nz_q[tgt_idx] <= 1'b1;
			end
			if (cmd.ready_init) begin
				ready_q    <= ~nz_q & nmask;
				emit_cnt_q <= '0;
			end else if (cmd.take_pick) begin
				ready_q[pick_next] <= 1'b0;
				pick_q             <= pick_next;
			end else if (cmd.deg_dec && deg_rdata == DEG_W'(1)) begin
				ready_q[tgt_idx] <= 1'b1;
			end
			if (cmd.emit_vertex) begin
				emit_cnt_q <= emit_cnt_q + VCNT_W'(1);
			end
			if (cmd.run_clear) begin
				edge_total_q <= '0;
				overflow_q   <= 1'b0;
				nz_q         <= '0;
			end
			if (cmd.emit_vertex || cmd.emit_fail) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.emit_vertex) begin
			vertex_index   <= VTX_W'(pick_q);
			vertex_valid   <= 1'b1;
			last_of_run    <= status.emit_last;
			order_complete <= status.emit_last;
			edges_dropped  <= status.emit_last && overflow_q;
		end else if (cmd.emit_fail) begin
			vertex_index   <= '0;
			vertex_valid   <= 1'b0;
			last_of_run    <= 1'b1;
			order_complete <= 1'b0;
			edges_dropped  <= overflow_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		status.total_zero  = (edge_total_q == '0);
		status.idx_last    = ((ET_W'(idx_q) + ET_W'(1)) == edge_total_q);
		status.clr_last    = (clr_q == IDX_W'(MAX_VERTICES - 1));
		status.cnt_hit     = ({1'b0, e_src} < n_eff) && ({1'b0, e_tgt} < n_eff);
		status.scan_hit    = (e_src == VTX_W'(pick_q)) && ({1'b0, e_tgt} < n_eff);
		status.ready_empty = (ready_q == '0);
		status.emit_last   = ((emit_cnt_q + VCNT_W'(1)) == n_eff);
		status.out_free    = !out_valid_q || out_ready;
	end

	a_deg_write_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_wr, cmd.deg_inc, cmd.deg_dec}))
		else $error("conflicting in-degree writes");

	a_emit_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_vertex || cmd.emit_fail) |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken item");

	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edge_total_q <= ET_W'(MAX_EDGES))
		else $error("edge count beyond store depth");

	a_pick_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_pick |=> !ready_q[$past(pick_next)])
		else $error("picked vertex still marked ready");

endmodule

`default_nettype wire

// ----- hdl/tps_controller.sv -----
// tps_controller: sequencer for edge loading, degree counting and the
// per-vertex relaxation scans. Uses tps_pkg; drives tps_datapath.
`default_nettype none

module tps_controller import tps_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_func,
	output logic        in_ready,
	input  tps_status_t status,
	output tps_cmd_t    cmd
);

	tps_state_t state_q;
	tps_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_func == FUNC_ADD) begin
						cmd.add_edge = 1'b1;
					end else begin
						state_next = ST_CLR;
					end
				end
			end
			ST_CLR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last) begin
					cmd.idx_clear = 1'b1;
					state_next    = status.total_zero ? ST_INIT : ST_CNT_EDGE;
				end
			end
			ST_CNT_EDGE: begin
				cmd.edge_rd = 1'b1;
				state_next  = ST_CNT_CHECK;
			end
			ST_CNT_CHECK: begin
				if (status.cnt_hit) begin
					cmd.deg_rd = 1'b1;
					state_next = ST_CNT_WRITE;
				end else if (status.idx_last) begin
					state_next = ST_INIT;
				end else begin
					cmd.idx_next = 1'b1;
					state_next   = ST_CNT_EDGE;
				end
			end
			ST_CNT_WRITE: begin
				cmd.deg_inc = 1'b1;
				if (status.idx_last) begin
					state_next = ST_INIT;
				end else begin
					cmd.idx_next = 1'b1;
					state_next   = ST_CNT_EDGE;
				end
			end
			ST_INIT: begin
				cmd.ready_init = 1'b1;
				state_next     = ST_PICK;
			end
			ST_PICK: begin
				if (status.ready_empty) begin
					state_next = ST_FAIL;
				end else begin
					cmd.take_pick = 1'b1;
					cmd.idx_clear = 1'b1;
					state_next    = status.total_zero ? ST_EMIT : ST_SCAN_EDGE;
				end
			end
			ST_SCAN_EDGE: begin
				cmd.edge_rd = 1'b1;
				state_next  = ST_SCAN_CHECK;
			end
			ST_SCAN_CHECK: begin
				if (status.scan_hit) begin
					cmd.deg_rd = 1'b1;
					state_next = ST_SCAN_WRITE;
				end else if (status.idx_last) begin
					state_next = ST_EMIT;
				end else begin
					cmd.idx_next = 1'b1;
					state_next   = ST_SCAN_EDGE;
				end
			end
			ST_SCAN_WRITE: begin
				cmd.deg_dec = 1'b1;
				if (status.idx_last) begin
					state_next = ST_EMIT;
				end else begin
					cmd.idx_next = 1'b1;
					state_next   = ST_SCAN_EDGE;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit_vertex = 1'b1;
					if (status.emit_last) begin
						cmd.run_clear = 1'b1;
						state_next    = ST_IDLE;
					end else begin
						state_next = ST_PICK;
					end
				end
			end
			ST_FAIL: begin
				if (status.out_free) begin
					cmd.emit_fail = 1'b1;
					cmd.run_clear = 1'b1;
					state_next    = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/min_first_topological_sort.sv -----
// Min-first topological sorter: add items stream in back to back while the sequencer idles.
// A finish item sweeps all MAX_VERTICES in-degree entries, counts in-degrees over the
// stored edges, then per emitted vertex picks the lowest ready one and scans the edges.
// Results wait in a one-item output register; the sequencer waits while it is not free.
// Reset clears control state and vertex_count (64); the edge store is not cleared and the
// in-degree table is swept at the start of every finish run.
`default_nettype none

module min_first_topological_sort import tps_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_we,
	input  wire [VCNT_W-1:0] cfg_wdata,
	tps_in_if.sink           cmd,
	tps_out_if.source        result
);

	// controller <-> datapath records
	tps_cmd_t    dp_cmd;
	tps_status_t dp_status;
	logic        in_ready;

	// command channel: ready only while the sequencer idles; an add item
	// is written straight into the edge store on the accepting edge, or dropped when it is full
	assign cmd.ready = in_ready;

	tps_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_func  (cmd.func),
		.in_ready (in_ready),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	// datapath holds the edge store, degree table, ready mask and the
	// output register that parts the result channel from the sequencer
	tps_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.source_vertex  (cmd.source_vertex),
		.target_vertex  (cmd.target_vertex),
		.cmd            (dp_cmd),
		.status         (dp_status),
		.out_valid      (result.valid),
		.out_ready      (result.ready),
		.vertex_index   (result.vertex_index),
		.vertex_valid   (result.vertex_valid),
		.last_of_run    (result.last_of_run),
		.order_complete (result.order_complete),
		.edges_dropped  (result.edges_dropped)
	);

endmodule

`default_nettype wire
